@@ design/nptv6_pkg.sv @@
// Shared types, constants and helper functions for the NPTv6 address translator.
// Used by nptv6_cfg, nptv6_xlate and nptv6_address_translator_core.
// Depends on nothing.
package nptv6_pkg;

    localparam int AddrWidth = 128;
    localparam int WordWidth = 16;
    localparam int NumWords  = AddrWidth / WordWidth;
    localparam int CfgWidth  = 64;
    localparam int LenWidth  = 7;

    localparam logic [WordWidth-1:0] ONES16      = 16'hFFFF;
    localparam logic [LenWidth-1:0]  MIN_ADJ_LEN = 7'd48;

    // Configuration register indexes
    localparam logic [2:0] REG_INSIDE_HI   = 3'd0;
    localparam logic [2:0] REG_INSIDE_LO   = 3'd1;
    localparam logic [2:0] REG_OUTSIDE_HI  = 3'd2;
    localparam logic [2:0] REG_OUTSIDE_LO  = 3'd3;
    localparam logic [2:0] REG_INSIDE_LEN  = 3'd4;
    localparam logic [2:0] REG_OUTSIDE_LEN = 3'd5;
    localparam logic [2:0] REG_DIRECTION   = 3'd6;
    localparam logic [2:0] REG_ICMP_EN     = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_UNREACH    = 2'd1;
    localparam logic [1:0] ST_PARAM      = 2'd2;
    localparam logic [1:0] ST_MISMATCH   = 2'd3;

    localparam logic KIND_HEADER = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } in_t;

    typedef struct packed {
        logic [63:0] new_addr_hi;
        logic [63:0] new_addr_lo;
        logic        blocked;
        logic [1:0]  status;
        logic        send_icmp;
    } out_t;

    // Values derived from the configuration registers
    typedef struct packed {
        logic [AddrWidth-1:0] target;
        logic [AddrWidth-1:0] adj_mask;
        logic [AddrWidth-1:0] over_mask;
        logic [AddrWidth-1:0] match_val;
        logic [AddrWidth-1:0] match_mask;
        logic [WordWidth-1:0] adj;
        logic [3:0]           nw;
        logic                 long_len;
        logic                 outbound;
        logic                 icmp_en;
    } cfg_t;

    function automatic logic [AddrWidth-1:0] len_mask(input logic [LenWidth-1:0] n);
        return ~({AddrWidth{1'b1}} >> n);
    endfunction

    function automatic logic [WordWidth-1:0] oc_add(input logic [WordWidth-1:0] a,
                                                    input logic [WordWidth-1:0] b);
        logic [WordWidth:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, s[WordWidth]};
    endfunction

endpackage

@@ design/nptv6_cfg.sv @@
// Configuration registers and the per-configuration values derived from them.
// Depends on nptv6_pkg.
module nptv6_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [nptv6_pkg::CfgWidth-1:0] cfg_wdata,
    output nptv6_pkg::cfg_t                cfg
);

    logic [63:0] inside_hi_reg;
    logic [63:0] inside_lo_reg;
    logic [63:0] outside_hi_reg;
    logic [63:0] outside_lo_reg;
    logic [nptv6_pkg::LenWidth-1:0] inside_len_reg;
    logic [nptv6_pkg::LenWidth-1:0] outside_len_reg;
    logic direction_reg;
    logic icmp_en_reg;

    nptv6_pkg::cfg_t derived_reg;
    nptv6_pkg::cfg_t derived_next;

    logic [nptv6_pkg::AddrWidth-1:0] ins_mask;
    logic [nptv6_pkg::AddrWidth-1:0] outs_mask;
    logic [nptv6_pkg::AddrWidth-1:0] ins_m;
    logic [nptv6_pkg::AddrWidth-1:0] outs_m;
    logic [nptv6_pkg::LenWidth-1:0]  max_len;
    logic [nptv6_pkg::LenWidth-1:0]  adj_len;
    logic [3:0]                      nw;
    logic [nptv6_pkg::WordWidth-1:0] in_w [nptv6_pkg::NumWords];
    logic [nptv6_pkg::WordWidth-1:0] out_w [nptv6_pkg::NumWords];
    logic [nptv6_pkg::WordWidth-1:0] sum_in;
    logic [nptv6_pkg::WordWidth-1:0] sum_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_hi_reg   <= '0;
            inside_lo_reg   <= '0;
            outside_hi_reg  <= '0;
            outside_lo_reg  <= '0;
            inside_len_reg  <= nptv6_pkg::MIN_ADJ_LEN;
            outside_len_reg <= nptv6_pkg::MIN_ADJ_LEN;
            direction_reg   <= 1'b0;
            icmp_en_reg     <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                nptv6_pkg::REG_INSIDE_HI:   inside_hi_reg   <= cfg_wdata;
                nptv6_pkg::REG_INSIDE_LO:   inside_lo_reg   <= cfg_wdata;
                nptv6_pkg::REG_OUTSIDE_HI:  outside_hi_reg  <= cfg_wdata;
                nptv6_pkg::REG_OUTSIDE_LO:  outside_lo_reg  <= cfg_wdata;
                nptv6_pkg::REG_INSIDE_LEN:  inside_len_reg  <= cfg_wdata[nptv6_pkg::LenWidth-1:0];
                nptv6_pkg::REG_OUTSIDE_LEN: outside_len_reg <= cfg_wdata[nptv6_pkg::LenWidth-1:0];
                nptv6_pkg::REG_DIRECTION:   direction_reg   <= cfg_wdata[0];
                nptv6_pkg::REG_ICMP_EN:     icmp_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ins_mask  = nptv6_pkg::len_mask(inside_len_reg);
        outs_mask = nptv6_pkg::len_mask(outside_len_reg);
        ins_m     = {inside_hi_reg, inside_lo_reg} & ins_mask;
        outs_m    = {outside_hi_reg, outside_lo_reg} & outs_mask;

        max_len = (inside_len_reg > outside_len_reg) ? inside_len_reg : outside_len_reg;
        adj_len = (max_len < nptv6_pkg::MIN_ADJ_LEN) ? nptv6_pkg::MIN_ADJ_LEN : max_len;
        nw      = {1'b0, adj_len[6:4]} + {3'b000, |adj_len[3:0]};

        for (int i = 0; i < nptv6_pkg::NumWords; i++)
        begin
            in_w[i]  = (4'(i) < nw) ? ins_m[(7-i)*16 +: 16] : '0;
            out_w[i] = (4'(i) < nw) ? outs_m[(7-i)*16 +: 16] : '0;
        end

        sum_in  = nptv6_pkg::oc_add(
                      nptv6_pkg::oc_add(nptv6_pkg::oc_add(in_w[0], in_w[1]),
                                        nptv6_pkg::oc_add(in_w[2], in_w[3])),
                      nptv6_pkg::oc_add(nptv6_pkg::oc_add(in_w[4], in_w[5]),
                                        nptv6_pkg::oc_add(in_w[6], in_w[7])));
        sum_out = nptv6_pkg::oc_add(
                      nptv6_pkg::oc_add(nptv6_pkg::oc_add(out_w[0], out_w[1]),
                                        nptv6_pkg::oc_add(out_w[2], out_w[3])),
                      nptv6_pkg::oc_add(nptv6_pkg::oc_add(out_w[4], out_w[5]),
                                        nptv6_pkg::oc_add(out_w[6], out_w[7])));

        derived_next.target     = direction_reg ? outs_m : ins_m;
        derived_next.adj_mask   = nptv6_pkg::len_mask(adj_len);
        derived_next.over_mask  = (direction_reg && (inside_len_reg < outside_len_reg)) ?
                                  (ins_mask ^ outs_mask) : '0;
        derived_next.match_val  = direction_reg ? {inside_hi_reg, inside_lo_reg}
                                                : {outside_hi_reg, outside_lo_reg};
        derived_next.match_mask = direction_reg ? ins_mask : outs_mask;
        derived_next.adj        = nptv6_pkg::oc_add(sum_in, ~sum_out);
        derived_next.nw         = nw;
        derived_next.long_len   = adj_len > nptv6_pkg::MIN_ADJ_LEN;
        derived_next.outbound   = direction_reg;
        derived_next.icmp_en    = icmp_en_reg;
    end

    always_ff @(posedge clk)
    begin
        derived_reg <= derived_next;
    end

    assign cfg = derived_reg;

endmodule

@@ design/nptv6_xlate.sv @@
// Translation datapath: word selection, prefix copy, ones-complement adjust, status.
// Depends on nptv6_pkg.
module nptv6_xlate (
    input  nptv6_pkg::in_t  item,
    input  nptv6_pkg::cfg_t cfg,
    output nptv6_pkg::out_t res
);

    logic [nptv6_pkg::AddrWidth-1:0] orig;
    logic [nptv6_pkg::AddrWidth-1:0] merged;
    logic [nptv6_pkg::AddrWidth-1:0] final_addr;
    logic [nptv6_pkg::AddrWidth-1:0] out_addr;
    logic [nptv6_pkg::WordWidth-1:0] v_old;
    logic [nptv6_pkg::WordWidth-1:0] v_sum;
    logic [nptv6_pkg::WordWidth-1:0] v_new;
    logic [2:0]                      pos;
    logic [6:0]                      base;
    logic                            found;
    logic                            over;
    logic                            mismatch;
    logic [1:0]                      tr_status;
    logic [1:0]                      status;
    logic                            blocked;

    always_comb
    begin
        orig = {item.addr_hi, item.addr_lo};

        pos   = 3'd0;
        found = 1'b0;
        for (int i = nptv6_pkg::NumWords - 1; i >= 0; i--)
        begin
            if ((4'(i) >= cfg.nw) && (orig[(7-i)*16 +: 16] != nptv6_pkg::ONES16) &&
                ((cfg.nw != 4'd3) || (i == 3)))
            begin
                pos   = 3'(i);
                found = 1'b1;
            end
        end

        base   = {~pos, 4'b0000};
        merged = (orig & ~cfg.adj_mask) | (cfg.target & cfg.adj_mask);
        v_old  = merged[base +: 16];
        v_sum  = nptv6_pkg::oc_add(v_old, cfg.outbound ? cfg.adj : ~cfg.adj);
        v_new  = (v_sum == nptv6_pkg::ONES16) ? '0 : v_sum;

        final_addr = merged;
        final_addr[base +: 16] = v_new;

        if (!found)
            tr_status = nptv6_pkg::ST_UNREACH;
        else if (cfg.long_len && (final_addr[63:0] == 64'd0))
            tr_status = nptv6_pkg::ST_PARAM;
        else
            tr_status = nptv6_pkg::ST_OK;

        over     = |(orig & cfg.over_mask);
        mismatch = |((orig ^ cfg.match_val) & cfg.match_mask);

        if (item.kind == nptv6_pkg::KIND_HEADER)
        begin
            status   = over ? nptv6_pkg::ST_UNREACH : tr_status;
            blocked  = status != nptv6_pkg::ST_OK;
            out_addr = blocked ? orig : final_addr;
        end
        else
        begin
            blocked = 1'b0;
            if (mismatch)
            begin
                status   = nptv6_pkg::ST_MISMATCH;
                out_addr = orig;
            end
            else
            begin
                status   = tr_status;
                out_addr = found ? final_addr : orig;
            end
        end

        res.new_addr_hi = out_addr[127:64];
        res.new_addr_lo = out_addr[63:0];
        res.blocked     = blocked;
        res.status      = status;
        res.send_icmp   = blocked & cfg.icmp_en;
    end

endmodule

@@ design/nptv6_address_translator_core.sv @@
// Top level of the NPTv6 address translator: input register, datapath, result register.
// Depends on nptv6_pkg, nptv6_cfg and nptv6_xlate.
//
//   channel   signals                              direction
//   in        in_valid / in_ready / in_data        transaction in
//   out       out_valid / out_ready / out_data     transaction out
//   cfg       cfg_wr_en / cfg_index / cfg_wdata    register write
//
// One transaction per cycle sustained while out_ready stays high; an accepted input passes
// through the input register and then the result register before out_valid rises.
// The derived configuration register takes up a register write in the following cycle.
// Reset clears both stage valid bits and loads the register reset values.
// in_ready drops only while both stages are full and out_ready is low;
// the stalled result holds in the result register.
module nptv6_address_translator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  nptv6_pkg::in_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output nptv6_pkg::out_t                out_data,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [nptv6_pkg::CfgWidth-1:0] cfg_wdata
);

    nptv6_pkg::cfg_t cfg;
    nptv6_pkg::in_t  s1_data_reg;
    nptv6_pkg::out_t out_data_reg;
    nptv6_pkg::out_t res;
    logic            s1_valid_reg;
    logic            out_valid_reg;
    logic            out_take;
    logic            s1_advance;

    nptv6_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nptv6_xlate u_xlate (
        .item (s1_data_reg),
        .cfg  (cfg),
        .res  (res)
    );

    assign out_take   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_take;
    assign in_ready   = !s1_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_take)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (s1_advance)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ verif/tb_nptv6_address_translator_core.sv @@
// Self-checking testbench for nptv6_address_translator_core: directed table, then random phases.
// Expected results: fixed table rows, else a behavioral NPTv6 predictor on the register shadow.
// Depends on nptv6_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_nptv6_address_translator_core;

    localparam logic KIND_EMBEDDED  = 1'b1;
    localparam int   NUM_PHASES     = 8;
    localparam int   PHASE_ITEMS    = 92;
    localparam int   SETTLE_CYCLES  = 4;
    localparam int   LONG_HOLD      = 300;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   MAX_REPORTS    = 30;

    typedef struct {
        logic [127:0] in_pfx;
        logic [127:0] ex_pfx;
        int unsigned  in_len;
        int unsigned  ex_len;
        logic         outbound;
        logic         icmp_en;
    } regs_t;

    typedef struct {
        bit               is_write;
        logic [2:0]       reg_idx;
        logic [63:0]      wval;
        nptv6_pkg::in_t   item;
        bit               fixed;
        nptv6_pkg::out_t  want;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    nptv6_pkg::in_t  in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    nptv6_pkg::out_t out_data;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [nptv6_pkg::CfgWidth-1:0] cfg_wdata = '0;

    regs_t       xl;
    nptv6_pkg::out_t addr_results[$];
    step_t       steps[$];
    nptv6_pkg::out_t mon_got;
    nptv6_pkg::out_t mon_want;
    bit          calm = 1'b0;
    bit          stall_req = 1'b0;
    int unsigned gap_odds = 4;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_settings = 0;
    int unsigned n_blocked = 0;
    int unsigned idle_cycles = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    nptv6_address_translator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [127:0] top_bits(input int unsigned n);
        logic [127:0] m;
        for (int i = 0; i < 128; i++)
        begin
            m[127 - i] = (i < n);
        end
        return m;
    endfunction

    function automatic logic [15:0] word_get(input logic [127:0] a, input int unsigned i);
        return a[127 - 16 * i -: 16];
    endfunction

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        s = {1'b0, s[15:0]} + {16'h0, s[16]};
        return s[15:0];
    endfunction

    function automatic logic [15:0] ones_sum(input logic [127:0] a, input int unsigned nw);
        logic [15:0] s;
        s = '0;
        for (int unsigned i = 0; i < nw && i < 8; i++)
        begin
            s = ones_add(s, word_get(a, i));
        end
        return s;
    endfunction

    function automatic void derive(output logic [15:0] adj, output int unsigned nw,
                                   output int unsigned alen);
        alen = (xl.in_len > xl.ex_len) ? xl.in_len : xl.ex_len;
        if (alen < 32'(nptv6_pkg::MIN_ADJ_LEN))
            alen = 32'(nptv6_pkg::MIN_ADJ_LEN);
        nw = (alen + 15) / 16;
        adj = ones_add(ones_sum(xl.in_pfx & top_bits(xl.in_len), nw),
                       ~ones_sum(xl.ex_pfx & top_bits(xl.ex_len), nw));
    endfunction

    function automatic logic [1:0] rewrite_prefix(input logic [127:0] a,
                                                  input logic [127:0] tgt,
                                                  input int unsigned alen,
                                                  input int unsigned nw,
                                                  input logic [15:0] adj,
                                                  input logic outb,
                                                  output logic [127:0] res);
        int unsigned pos;
        logic [127:0] m;
        logic [15:0] v;
        res = a;
        pos = nw;
        if (nw == 3)
        begin
            if (word_get(a, 3) == nptv6_pkg::ONES16)
                return nptv6_pkg::ST_UNREACH;
        end
        else
        begin
            while (pos < 8 && word_get(a, pos) == nptv6_pkg::ONES16)
                pos++;
            if (pos >= 8)
                return nptv6_pkg::ST_UNREACH;
        end
        m = top_bits(alen);
        res = (a & ~m) | (tgt & m);
        v = word_get(res, pos);
        v = outb ? ones_add(v, adj) : ones_add(v, ~adj);
        if (v == nptv6_pkg::ONES16)
            v = '0;
        res[127 - 16 * pos -: 16] = v;
        if (alen > 32'(nptv6_pkg::MIN_ADJ_LEN) && res[63:0] == '0)
            return nptv6_pkg::ST_PARAM;
        return nptv6_pkg::ST_OK;
    endfunction

    function automatic nptv6_pkg::out_t predict_translation(input nptv6_pkg::in_t x);
        logic [127:0] orig, a, tgt, match, mm;
        logic [15:0] adj;
        int unsigned alen, nw;
        logic [1:0] st;
        nptv6_pkg::out_t r;
        orig = {x.addr_hi, x.addr_lo};
        a = orig;
        r = '0;
        derive(adj, nw, alen);
        tgt = xl.outbound ? (xl.ex_pfx & top_bits(xl.ex_len)) : (xl.in_pfx & top_bits(xl.in_len));
        if (x.kind == nptv6_pkg::KIND_HEADER)
        begin
            if (xl.outbound && xl.in_len < xl.ex_len
                && (orig & (top_bits(xl.in_len) ^ top_bits(xl.ex_len))) != '0)
                st = nptv6_pkg::ST_UNREACH;
            else
                st = rewrite_prefix(orig, tgt, alen, nw, adj, xl.outbound, a);
            if (st != nptv6_pkg::ST_OK)
            begin
                r.blocked = 1'b1;
                r.send_icmp = xl.icmp_en;
                a = orig;
            end
        end
        else
        begin
            match = xl.outbound ? xl.in_pfx : xl.ex_pfx;
            mm = top_bits(xl.outbound ? xl.in_len : xl.ex_len);
            if (((orig ^ match) & mm) != '0)
                st = nptv6_pkg::ST_MISMATCH;
            else
                st = rewrite_prefix(orig, tgt, alen, nw, adj, xl.outbound, a);
        end
        r.new_addr_hi = a[127:64];
        r.new_addr_lo = a[63:0];
        r.status = st;
        return r;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_prefix();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic nptv6_pkg::in_t make_item();
        nptv6_pkg::in_t x;
        logic [127:0] a, m, src;
        logic [15:0] adj;
        int unsigned slen, alen, nw, i;
        x.kind = 1'($urandom_range(0, 1));
        a = rand128();
        derive(adj, nw, alen);
        if ($urandom_range(0, 9) < 7)
        begin
            src  = xl.outbound ? xl.in_pfx : xl.ex_pfx;
            slen = xl.outbound ? xl.in_len : xl.ex_len;
            m = top_bits(slen);
            a = (src & m) | (a & ~m);
            if (xl.outbound && xl.in_len < xl.ex_len && $urandom_range(0, 9) != 0)
                a = a & ~(top_bits(xl.in_len) ^ top_bits(xl.ex_len));
            if (nw < 8 && $urandom_range(0, 5) == 0)
            begin
                i = nw;
                do
                begin
                    a[127 - 16 * i -: 16] = nptv6_pkg::ONES16;
                    i++;
                end
                while (i < 8 && $urandom_range(0, 1) == 1);
            end
            else if (alen > 32'(nptv6_pkg::MIN_ADJ_LEN) && nw < 8 && $urandom_range(0, 5) == 0)
            begin
                a[63:0] = src[63:0] & m[63:0];
                a[127 - 16 * nw -: 16] = xl.outbound ? ~adj : adj;
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: a = '0;
                1: a = '1;
                default: ;
            endcase
        end
        x.addr_hi = a[127:64];
        x.addr_lo = a[63:0];
        return x;
    endfunction

    function automatic step_t cfg_row(input logic [2:0] idx, input logic [63:0] val);
        step_t s;
        s = '{default: '0};
        s.is_write = 1'b1;
        s.reg_idx = idx;
        s.wval = val;
        return s;
    endfunction

    function automatic step_t item_row(input logic kind, input logic [63:0] hi,
                                       input logic [63:0] lo);
        step_t s;
        s = '{default: '0};
        s.item.kind = kind;
        s.item.addr_hi = hi;
        s.item.addr_lo = lo;
        return s;
    endfunction

    function automatic step_t known_row(input logic kind, input logic [63:0] hi,
                                        input logic [63:0] lo, input logic [63:0] ohi,
                                        input logic [63:0] olo, input logic blk,
                                        input logic [1:0] st, input logic icmp);
        step_t s;
        s = item_row(kind, hi, lo);
        s.fixed = 1'b1;
        s.want.new_addr_hi = ohi;
        s.want.new_addr_lo = olo;
        s.want.blocked = blk;
        s.want.status = st;
        s.want.send_icmp = icmp;
        return s;
    endfunction

    task automatic send(input nptv6_pkg::in_t x, input bit fixed, input nptv6_pkg::out_t want);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (!in_ready);
        addr_results.push_back(fixed ? want : predict_translation(x));
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (addr_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            nptv6_pkg::REG_INSIDE_HI:   xl.in_pfx[127:64] = val;
            nptv6_pkg::REG_INSIDE_LO:   xl.in_pfx[63:0] = val;
            nptv6_pkg::REG_OUTSIDE_HI:  xl.ex_pfx[127:64] = val;
            nptv6_pkg::REG_OUTSIDE_LO:  xl.ex_pfx[63:0] = val;
            nptv6_pkg::REG_INSIDE_LEN:  xl.in_len = 32'(val[6:0]);
            nptv6_pkg::REG_OUTSIDE_LEN: xl.ex_len = 32'(val[6:0]);
            nptv6_pkg::REG_DIRECTION:   xl.outbound = val[0];
            nptv6_pkg::REG_ICMP_EN:     xl.icmp_en = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic reg_close();
        cfg_wr_en <= 1'b0;
        n_settings++;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input int unsigned p);
        logic [6:0] il, ol;
        case (p)
            0: begin il = 7'd16;  ol = 7'd16;  end
            1: begin il = 7'd112; ol = 7'd112; end
            2: begin il = 7'd16;  ol = 7'd112; end
            3: begin il = 7'd112; ol = 7'd16;  end
            default:
            begin
                il = 7'($urandom_range(16, 112));
                ol = ($urandom_range(0, 3) == 0) ? il : 7'($urandom_range(16, 112));
            end
        endcase
        drain();
        reg_write(nptv6_pkg::REG_INSIDE_HI, pick_prefix());
        reg_write(nptv6_pkg::REG_INSIDE_LO, pick_prefix());
        reg_write(nptv6_pkg::REG_OUTSIDE_HI, pick_prefix());
        reg_write(nptv6_pkg::REG_OUTSIDE_LO, pick_prefix());
        reg_write(nptv6_pkg::REG_INSIDE_LEN, {57'h0, il});
        reg_write(nptv6_pkg::REG_OUTSIDE_LEN, {57'h0, ol});
        reg_write(nptv6_pkg::REG_DIRECTION,
                  (p < 4) ? 64'(p % 2) : 64'($urandom_range(0, 1)));
        reg_write(nptv6_pkg::REG_ICMP_EN,
                  (p < 4) ? 64'((p / 2) % 2) : 64'($urandom_range(0, 1)));
        reg_close();
    endtask

    task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            mon_got = out_data;
            n_checked++;
            status_seen[mon_got.status]++;
            if (mon_got.blocked)
                n_blocked++;
            if (addr_results.size() == 0)
            begin
                report("unexpected transaction", '0, mon_got.new_addr_lo);
            end
            else
            begin
                mon_want = addr_results.pop_front();
                if (mon_got.new_addr_hi !== mon_want.new_addr_hi)
                    report("new_addr_hi", mon_want.new_addr_hi, mon_got.new_addr_hi);
                if (mon_got.new_addr_lo !== mon_want.new_addr_lo)
                    report("new_addr_lo", mon_want.new_addr_lo, mon_got.new_addr_lo);
                if (mon_got.blocked !== mon_want.blocked)
                    report("blocked", 64'(mon_want.blocked), 64'(mon_got.blocked));
                if (mon_got.status !== mon_want.status)
                    report("status", 64'(mon_want.status), 64'(mon_got.status));
                if (mon_got.send_icmp !== mon_want.send_icmp)
                    report("send_icmp", 64'(mon_want.send_icmp), 64'(mon_got.send_icmp));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: timeout, no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, addr_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : sink_side
        @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                stall_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin : main_seq
        bit writing;
        nptv6_pkg::out_t none;
        none = '0;
        writing = 1'b0;
        xl.in_pfx = '0;
        xl.ex_pfx = '0;
        xl.in_len = 32'(nptv6_pkg::MIN_ADJ_LEN);
        xl.ex_len = 32'(nptv6_pkg::MIN_ADJ_LEN);
        xl.outbound = 1'b0;
        xl.icmp_en = 1'b1;

        // reset values
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'h2001_0db8_1234_5678, 64'h1,
                                  64'h0000_0000_0000_5678, 64'h1, 1'b0,
                                  nptv6_pkg::ST_OK, 1'b0));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'h2001_0db8_1234_ffff, 64'h5,
                                  64'h2001_0db8_1234_ffff, 64'h5, 1'b1,
                                  nptv6_pkg::ST_UNREACH, 1'b1));
        steps.push_back(known_row(KIND_EMBEDDED, 64'h2001_0db8_1234_5678, 64'h7,
                                  64'h2001_0db8_1234_5678, 64'h7, 1'b0,
                                  nptv6_pkg::ST_MISMATCH, 1'b0));
        steps.push_back(known_row(KIND_EMBEDDED, 64'h0000_0000_0000_abcd, 64'h9,
                                  64'h0000_0000_0000_abcd, 64'h9, 1'b0,
                                  nptv6_pkg::ST_OK, 1'b0));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, '1, '1, '1, '1, 1'b1,
                                  nptv6_pkg::ST_UNREACH, 1'b1));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, '0, '0, '0, '0, 1'b0,
                                  nptv6_pkg::ST_OK, 1'b0));
        // zero interface ID with L of 64, ICMP errors off
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_LEN, 64'd64));
        steps.push_back(cfg_row(nptv6_pkg::REG_ICMP_EN, 64'd0));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'h2001_0db8_0000_1111, 64'h0,
                                  64'h2001_0db8_0000_1111, 64'h0, 1'b1,
                                  nptv6_pkg::ST_PARAM, 1'b0));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'h0, '1, 64'h0, '1, 1'b1,
                                  nptv6_pkg::ST_UNREACH, 1'b0));
        steps.push_back(known_row(KIND_EMBEDDED, 64'h0000_0000_0000_2222, 64'h0,
                                  64'h0, 64'h0, 1'b0, nptv6_pkg::ST_PARAM, 1'b0));
        steps.push_back(item_row(nptv6_pkg::KIND_HEADER, 64'h2001_0db8_aaaa_bbbb,
                                 64'h0123_4567_89ab_cdef));
        // real prefixes, outbound
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_HI, 64'hfd01_0203_0405_0000));
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_LO, 64'h0));
        steps.push_back(cfg_row(nptv6_pkg::REG_OUTSIDE_HI, 64'h2001_0db8_0001_0000));
        steps.push_back(cfg_row(nptv6_pkg::REG_OUTSIDE_LO, 64'h0));
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_LEN, 64'd48));
        steps.push_back(cfg_row(nptv6_pkg::REG_DIRECTION, 64'd1));
        steps.push_back(cfg_row(nptv6_pkg::REG_ICMP_EN, 64'd1));
        steps.push_back(item_row(nptv6_pkg::KIND_HEADER, 64'hfd01_0203_0405_1234,
                                 64'h1111_2222_3333_4444));
        steps.push_back(item_row(KIND_EMBEDDED, 64'hfd01_0203_0405_aaaa, 64'h0));
        steps.push_back(known_row(KIND_EMBEDDED, 64'h2001_0db8_0001_0005, 64'h77,
                                  64'h2001_0db8_0001_0005, 64'h77, 1'b0,
                                  nptv6_pkg::ST_MISMATCH, 1'b0));
        steps.push_back(item_row(nptv6_pkg::KIND_HEADER, 64'hfd01_0203_0405_0000,
                                 64'hffff_ffff_ffff_0001));
        // non-overlapping bits set outbound
        steps.push_back(cfg_row(nptv6_pkg::REG_OUTSIDE_LEN, 64'd64));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'hfd01_0203_0405_0001, 64'h1,
                                  64'hfd01_0203_0405_0001, 64'h1, 1'b1,
                                  nptv6_pkg::ST_UNREACH, 1'b1));
        steps.push_back(item_row(nptv6_pkg::KIND_HEADER, 64'hfd01_0203_0405_0000,
                                 64'h8000_0000_0000_0001));
        // prefix above 112 leaves no usable word
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_LEN, 64'd120));
        steps.push_back(known_row(nptv6_pkg::KIND_HEADER, 64'hfd01_0203_0405_0000, 64'h1234,
                                  64'hfd01_0203_0405_0000, 64'h1234, 1'b1,
                                  nptv6_pkg::ST_UNREACH, 1'b1));
        steps.push_back(known_row(KIND_EMBEDDED, 64'hfd01_0203_0405_0000, 64'hff,
                                  64'hfd01_0203_0405_0000, 64'hff, 1'b0,
                                  nptv6_pkg::ST_UNREACH, 1'b0));
        // prefix below 16, inbound
        steps.push_back(cfg_row(nptv6_pkg::REG_INSIDE_LEN, 64'd8));
        steps.push_back(cfg_row(nptv6_pkg::REG_OUTSIDE_LEN, 64'd16));
        steps.push_back(cfg_row(nptv6_pkg::REG_DIRECTION, 64'd0));
        steps.push_back(item_row(nptv6_pkg::KIND_HEADER, 64'h2001_0db8_0001_0002,
                                 64'hffff_0000_0000_0000));
        steps.push_back(item_row(KIND_EMBEDDED, 64'h2001_ffff_ffff_ffff, '1));
        steps.push_back(item_row(KIND_EMBEDDED, '1, '1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_write)
            begin
                if (!writing)
                begin
                    drain();
                    writing = 1'b1;
                end
                reg_write(steps[i].reg_idx, steps[i].wval);
            end
            else
            begin
                if (writing)
                begin
                    reg_close();
                    writing = 1'b0;
                end
                send(steps[i].item, steps[i].fixed, steps[i].want);
            end
        end

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            load_setting(p);
            calm = (p == NUM_PHASES - 1);
            gap_odds = (p % 3 == 1) ? 0 : 5;
            for (int unsigned k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 2 && k == 10)
                    stall_req = 1'b1;
                if (p == 4 && k == 40)
                    drain();
                send(make_item(), 1'b0, none);
            end
        end

        drain();
        repeat (16) @(posedge clk);

        $display("%0d transactions sent, %0d checked, across %0d register settings",
                 n_sent, n_checked, n_settings);
        $display("status mix: ok %0d, unreachable %0d, param problem %0d, mismatch %0d; blocked %0d",
                 status_seen[nptv6_pkg::ST_OK], status_seen[nptv6_pkg::ST_UNREACH],
                 status_seen[nptv6_pkg::ST_PARAM], status_seen[nptv6_pkg::ST_MISMATCH],
                 n_blocked);
        if (n_errors == 0 && addr_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d errors, %0d results outstanding", n_errors, addr_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
